// ===== rtl/core/pmp_pkg.sv =====
`timescale 1ns / 1ps

package pmp_pkg;

   // One vertex as it arrives on the request side
   typedef struct packed {
      logic signed [15:0] vertex_x;
      logic signed [15:0] vertex_y;
      logic [31:0]        body_mass;
      logic               last;
   } req_type;

   // One result for a closed polygon
   typedef struct packed {
      logic [39:0]        area;
      logic signed [15:0] centroid_x;
      logic signed [15:0] centroid_y;
      logic signed [63:0] inertia;
      logic               degenerate;
      logic               overflowed;
   } rsp_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EDGE = 4'b0010,
      S_MULN = 4'b0100,
      S_DIV  = 4'b1000
   } state_type;

   // What the shared divider is working on
   typedef enum logic [1:0] {
      DIV_CX,
      DIV_CY,
      DIV_IN
   } div_sel_type;

   // Edge pass: 11 multiplies issued, the last product folded in at this final step
   localparam logic [3:0] EDGE_LAST_STEP = 4'd11;
   // Mass times |inertia sum|: four 16-bit chunks, then one load step
   localparam logic [3:0] MULN_LOAD_STEP = 4'd5;

   localparam int         SUM_W   = 24;
   localparam int         NUM_W   = 96;
   localparam int         DEN_W   = 51;
   localparam logic [6:0] CEN_ITERS = 7'd24;
   localparam logic [6:0] IN_ITERS  = 7'd96;

   localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

endpackage

// ===== rtl/core/polygon_mass_properties.sv =====
`timescale 1ns / 1ps

// Polygon mass properties. Vertices (signed Q8.8) are transferred one at a time with
// start while busy is low; the transfer with last set closes the ring to the first
// vertex and then one result is shown on rsp_data for exactly one cycle
// with rsp_valid high. The receiver cannot stall: it must take the result in that cycle.
// All arithmetic runs through one 34x18 signed multiplier and one restoring divider
// (one quotient bit a cycle). The first vertex of a polygon, unless it is also the last,
// does not make the block busy; every further vertex that is kept runs an edge pass
// on the multiplier. The last vertex runs its own edge, if kept and not the first, then
// the closing edge, both centroid divisions and, unless the polygon is degenerate, a mass
// multiplication and an inertia division. Vertices beyond MAX_VERTICES are dropped and
// reported in the result's overflowed flag.
module polygon_mass_properties #(
   parameter int MAX_VERTICES = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  pmp_pkg::req_type req_data,
   output logic            rsp_valid,
   output pmp_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int SW    = pmp_pkg::SUM_W;
   localparam int NW    = pmp_pkg::NUM_W;
   localparam int DW    = pmp_pkg::DEN_W;

   // Registers
   pmp_pkg::state_type   state_ff, state_in;
   pmp_pkg::div_sel_type dsel_ff, dsel_in;
   logic [3:0]           step_ff, step_in;
   logic                 close_ff, close_in;
   logic                 last_ff, last_in;
   logic [31:0]          mass_ff, mass_in;
   logic signed [15:0]   px_ff, px_in, py_ff, py_in, qx_ff, qx_in, qy_ff, qy_in;
   logic signed [15:0]   first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [15:0]   prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [47:0]   shoe_ff, shoe_in, cross_ff, cross_in;
   logic signed [63:0]   inert_ff, inert_in;
   logic signed [SW-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 dropped_ff, dropped_in;
   logic signed [32:0]   a_ff, a_in;
   logic signed [34:0]   b_ff, b_in;
   logic signed [51:0]   prod_ff, prod_in;
   logic [NW-1:0]        nacc_ff, nacc_in, num_ff, num_in, quo_ff, quo_in;
   logic [DW-1:0]        rem_ff, rem_in, den_ff, den_in;
   logic [6:0]           iter_ff, iter_in;
   logic signed [15:0]   cx_ff, cx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pmp_pkg::rsp_type     rsp_ff, rsp_in;

   // Shared arithmetic and helpers
   logic signed [33:0]   mul_a;
   logic signed [17:0]   mul_b;
   logic signed [51:0]   mul_p;
   logic                 accept, vtx_ok;
   logic [SW-1:0]        sx_mag, sy_mag;
   logic [63:0]          m_abs, lim, qv, inert_res;
   logic [47:0]          c_abs, shoe_abs;
   logic [DW:0]          trial, trial_diff;
   logic                 ge, neg_in, sat;
   logic [15:0]          cq;

   assign busy      = (state_ff != pmp_pkg::S_IDLE);
   assign accept    = start && !busy;
   assign vtx_ok    = (count_ff < CNT_W'(MAX_VERTICES));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Magnitudes
   assign sx_mag   = sum_x_ff[SW-1] ? SW'(-sum_x_ff) : SW'(sum_x_ff);
   assign sy_mag   = sum_y_ff[SW-1] ? SW'(-sum_y_ff) : SW'(sum_y_ff);
   assign m_abs    = inert_ff[63] ? 64'(-inert_ff) : 64'(inert_ff);
   assign c_abs    = cross_ff[47] ? 48'(-cross_ff) : 48'(cross_ff);
   assign shoe_abs = shoe_ff[47] ? 48'(-shoe_ff) : 48'(shoe_ff);

   // Divider step: one quotient bit
   assign trial      = {rem_ff, num_ff[NW-1]};
   assign ge         = (trial >= {1'b0, den_ff});
   assign trial_diff = trial - {1'b0, den_ff};

   // Inertia sign and saturation
   assign neg_in    = inert_ff[63] ^ cross_ff[47];
   assign lim       = neg_in ? pmp_pkg::NEG_LIMIT : pmp_pkg::POS_LIMIT;
   assign sat       = (|quo_ff[NW-1:64]) || (quo_ff[63:0] > lim);
   assign qv        = sat ? lim : quo_ff[63:0];
   assign inert_res = neg_in ? 64'(-qv) : qv;
   assign cq        = quo_ff[15:0];

   // Operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == pmp_pkg::S_EDGE) begin
         case (step_ff)
            4'd0: begin mul_a = 34'(qx_ff); mul_b = 18'(py_ff); end
            4'd1: begin mul_a = 34'(qy_ff); mul_b = 18'(px_ff); end
            4'd2: begin mul_a = 34'(px_ff); mul_b = 18'(px_ff); end
            4'd3: begin mul_a = 34'(py_ff); mul_b = 18'(py_ff); end
            4'd4: begin mul_a = 34'(px_ff); mul_b = 18'(qx_ff); end
            4'd5: begin mul_a = 34'(py_ff); mul_b = 18'(qy_ff); end
            4'd6: begin mul_a = 34'(qx_ff); mul_b = 18'(qx_ff); end
            4'd7: begin mul_a = 34'(qy_ff); mul_b = 18'(qy_ff); end
            4'd8: begin
               mul_a = 34'(17'(px_ff) + 17'(qx_ff));
               mul_b = 18'(17'(py_ff) - 17'(qy_ff));
            end
            4'd9: begin
               mul_a = 34'(a_ff);
               mul_b = $signed({1'b0, b_ff[32:16]});
            end
            4'd10: begin
               mul_a = 34'(a_ff);
               mul_b = $signed({2'b00, b_ff[15:0]});
            end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == pmp_pkg::S_MULN) begin
         mul_a = $signed({2'b00, mass_ff});
         mul_b = $signed({2'b00, m_abs[{step_ff[1:0], 4'b0000} +: 16]});
      end
   end

   assign mul_p = mul_a * mul_b;

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      dsel_in      = dsel_ff;
      step_in      = step_ff;
      close_in     = close_ff;
      last_in      = last_ff;
      mass_in      = mass_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      shoe_in      = shoe_ff;
      cross_in     = cross_ff;
      inert_in     = inert_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      prod_in      = mul_p;
      nacc_in      = nacc_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      iter_in      = iter_ff;
      cx_in        = cx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      case (state_ff)
         pmp_pkg::S_IDLE: begin
            if (accept) begin
               mass_in = req_data.body_mass;
               last_in = req_data.last;
               step_in = '0;
               if (vtx_ok) begin
                  prev_x_in = req_data.vertex_x;
                  prev_y_in = req_data.vertex_y;
                  if (count_ff == '0) begin
                     first_x_in = req_data.vertex_x;
                     first_y_in = req_data.vertex_y;
                  end
                  sum_x_in = sum_x_ff + SW'(req_data.vertex_x);
                  sum_y_in = sum_y_ff + SW'(req_data.vertex_y);
                  count_in = count_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
               if (vtx_ok && count_ff != '0) begin
                  // edge from the previous vertex to this one
                  px_in    = prev_x_ff;
                  py_in    = prev_y_ff;
                  qx_in    = req_data.vertex_x;
                  qy_in    = req_data.vertex_y;
                  close_in = req_data.last;
                  state_in = pmp_pkg::S_EDGE;
               end else if (req_data.last) begin
                  // only the closing edge remains
                  px_in    = vtx_ok ? req_data.vertex_x : prev_x_ff;
                  py_in    = vtx_ok ? req_data.vertex_y : prev_y_ff;
                  qx_in    = vtx_ok ? req_data.vertex_x : first_x_ff;
                  qy_in    = vtx_ok ? req_data.vertex_y : first_y_ff;
                  close_in = 1'b0;
                  state_in = pmp_pkg::S_EDGE;
               end
            end
         end

         pmp_pkg::S_EDGE: begin
            step_in = step_ff + 1'b1;
            // fold in the registered product issued at the previous step
            case (step_ff)
               4'd1: a_in = 33'(prod_ff);
               4'd2: a_in = a_ff - 33'(prod_ff);
               4'd3: b_in = 35'(prod_ff);
               4'd4, 4'd5, 4'd6, 4'd7, 4'd8: b_in = b_ff + 35'(prod_ff);
               4'd9: shoe_in = shoe_ff + 48'(prod_ff);
               4'd10: inert_in = inert_ff + 64'(prod_ff);
               4'd11: begin
                  inert_in = inert_ff + 64'(prod_ff >>> 16);
                  cross_in = cross_ff + 48'(a_ff);
               end
               default: ;
            endcase
            if (step_ff == pmp_pkg::EDGE_LAST_STEP) begin
               step_in = '0;
               if (close_ff) begin
                  px_in    = prev_x_ff;
                  py_in    = prev_y_ff;
                  qx_in    = first_x_ff;
                  qy_in    = first_y_ff;
                  close_in = 1'b0;
               end else if (last_ff) begin
                  num_in   = {sx_mag, {(NW - SW){1'b0}}};
                  den_in   = DW'(count_ff);
                  rem_in   = '0;
                  quo_in   = '0;
                  iter_in  = pmp_pkg::CEN_ITERS;
                  dsel_in  = pmp_pkg::DIV_CX;
                  state_in = pmp_pkg::S_DIV;
               end else begin
                  state_in = pmp_pkg::S_IDLE;
               end
            end
         end

         pmp_pkg::S_MULN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == '0) begin
               nacc_in = '0;
            end else if (step_ff != pmp_pkg::MULN_LOAD_STEP) begin
               nacc_in = nacc_ff + (NW'(prod_ff[47:0]) << {step_ff[1:0] - 2'd1, 4'b0000});
            end else begin
               num_in   = nacc_ff;
               den_in   = DW'({c_abs, 2'b00}) + DW'({c_abs, 1'b0});
               rem_in   = '0;
               quo_in   = '0;
               iter_in  = pmp_pkg::IN_ITERS;
               dsel_in  = pmp_pkg::DIV_IN;
               state_in = pmp_pkg::S_DIV;
            end
         end

         pmp_pkg::S_DIV: begin
            if (iter_ff != '0) begin
               rem_in  = ge ? trial_diff[DW-1:0] : trial[DW-1:0];
               num_in  = num_ff << 1;
               quo_in  = {quo_ff[NW-2:0], ge};
               iter_in = iter_ff - 1'b1;
            end else begin
               case (dsel_ff)
                  pmp_pkg::DIV_CX: begin
                     cx_in   = (count_ff == '0) ? 16'sd0 :
                               (sum_x_ff[SW-1] ? $signed(16'(-cq)) : $signed(cq));
                     num_in  = {sy_mag, {(NW - SW){1'b0}}};
                     rem_in  = '0;
                     quo_in  = '0;
                     iter_in = pmp_pkg::CEN_ITERS;
                     dsel_in = pmp_pkg::DIV_CY;
                  end
                  pmp_pkg::DIV_CY: begin
                     rsp_in.area       = shoe_abs[40:1];
                     rsp_in.centroid_x = cx_ff;
                     rsp_in.centroid_y = (count_ff == '0) ? 16'sd0 :
                        (sum_y_ff[SW-1] ? $signed(16'(-cq)) : $signed(cq));
                     rsp_in.overflowed = dropped_ff;
                     rsp_in.inertia    = '0;
                     rsp_in.degenerate = (cross_ff == '0);
                     if (cross_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        state_in     = pmp_pkg::S_IDLE;
                     end else begin
                        step_in  = '0;
                        state_in = pmp_pkg::S_MULN;
                     end
                  end
                  pmp_pkg::DIV_IN: begin
                     rsp_in.inertia = $signed(inert_res);
                     rsp_valid_in   = 1'b1;
                     state_in       = pmp_pkg::S_IDLE;
                  end
                  default: state_in = pmp_pkg::S_IDLE;
               endcase
               // polygon finished: accumulators back to their start values
               if (rsp_valid_in) begin
                  first_x_in = '0;
                  first_y_in = '0;
                  prev_x_in  = '0;
                  prev_y_in  = '0;
                  shoe_in    = '0;
                  cross_in   = '0;
                  inert_in   = '0;
                  sum_x_in   = '0;
                  sum_y_in   = '0;
                  count_in   = '0;
                  dropped_in = 1'b0;
               end
            end
         end

         default: state_in = pmp_pkg::S_IDLE;
      endcase
   end

   // Control and accumulator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmp_pkg::S_IDLE;
         step_ff      <= '0;
         close_ff     <= 1'b0;
         last_ff      <= 1'b0;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         shoe_ff      <= '0;
         cross_ff     <= '0;
         inert_ff     <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         close_ff     <= close_in;
         last_ff      <= last_in;
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         shoe_ff      <= shoe_in;
         cross_ff     <= cross_in;
         inert_ff     <= inert_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dsel_ff <= dsel_in;
      mass_ff <= mass_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      nacc_ff <= nacc_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cx_ff   <= cx_in;
      rsp_ff  <= rsp_in;
   end

   // Checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> rsp_data.inertia == 64'sd0)
      else $error("degenerate result with nonzero inertia");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.last |=> busy)
      else $error("last vertex transfer did not start the closing work");

   a_edge_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == pmp_pkg::S_EDGE |-> step_ff <= pmp_pkg::EDGE_LAST_STEP)
      else $error("edge step counter out of range");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   pmp_pkg::req_type req_data;
   logic             rsp_valid;
   pmp_pkg::rsp_type rsp_data;

   polygon_mass_properties dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   localparam int POLY_CAPACITY = 64;

   // 8 ns clock
   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // Running polygon accumulators, mirrored from the block
   int      first_vx, first_vy, prev_vx, prev_vy;
   longint  shoelace_acc, cross_acc, inertia_acc;
   int      sum_vx, sum_vy, held_count;
   bit      ring_dropped;

   pmp_pkg::rsp_type mass_props_q[$];
   int      mismatches;
   int      results_seen;
   int      polygons_sent;
   int      items_sent;
   int      overflow_polys;

   // Hand-typed expectation travelling with the vertex that carries it
   bit               pin_flag;
   pmp_pkg::rsp_type pin_exp;

   function automatic pmp_pkg::rsp_type mk_rsp(logic [39:0] area, logic [15:0] cx,
                                               logic [15:0] cy, logic [63:0] inertia,
                                               logic degenerate, logic overflowed);
      pmp_pkg::rsp_type r;
      r.area       = area;
      r.centroid_x = cx;
      r.centroid_y = cy;
      r.inertia    = inertia;
      r.degenerate = degenerate;
      r.overflowed = overflowed;
      return r;
   endfunction

   function automatic void clear_polygon();
      first_vx = 0; first_vy = 0; prev_vx = 0; prev_vy = 0;
      shoelace_acc = 0; cross_acc = 0; inertia_acc = 0;
      sum_vx = 0; sum_vy = 0; held_count = 0;
      ring_dropped = 1'b0;
   endfunction

   // One edge p -> q: shoelace, cross and inertia contributions
   function automatic void fold_edge(longint px, longint py, longint qx, longint qy);
      longint a, b, b_hi, b_lo;
      shoelace_acc += (px + qx) * (py - qy);
      a = qx * py - qy * px;
      b = px * px + py * py + px * qx + py * qy + qx * qx + qy * qy;
      b_hi = b >>> 16;
      b_lo = b & 64'hFFFF;
      inertia_acc += a * b_hi + ((a * b_lo) >>> 16);
      cross_acc += a;
   endfunction

   // mass * |inertia| / (6 * |cross|), truncated, saturated, signed
   function automatic logic [63:0] moment_of_inertia(logic [31:0] mass);
      bit           neg;
      logic [63:0]  mag_i, mag_c, limit;
      logic [127:0] num, den, quo;
      neg   = (inertia_acc < 0) != (cross_acc < 0);
      mag_i = inertia_acc < 0 ? 64'(-inertia_acc) : 64'(inertia_acc);
      mag_c = cross_acc < 0 ? 64'(-cross_acc) : 64'(cross_acc);
      num   = 128'(mass) * 128'(mag_i);
      den   = 128'(mag_c) * 128'd6;
      quo   = num / den;
      limit = neg ? pmp_pkg::NEG_LIMIT : pmp_pkg::POS_LIMIT;
      if (quo > 128'(limit))
         quo = 128'(limit);
      return neg ? -quo[63:0] : quo[63:0];
   endfunction

   // Advance the polygon by one vertex; returns 1 with a result on the last one
   function automatic bit take_vertex(pmp_pkg::req_type v, output pmp_pkg::rsp_type res);
      int          x, y;
      longint      mag;
      logic [15:0] cx, cy;
      x = v.vertex_x;
      y = v.vertex_y;
      res = '0;
      if (held_count >= POLY_CAPACITY) begin
         ring_dropped = 1'b1;
      end else begin
         if (held_count == 0) begin
            first_vx = x;
            first_vy = y;
         end else begin
            fold_edge(prev_vx, prev_vy, x, y);
         end
         prev_vx = x;
         prev_vy = y;
         sum_vx += x;
         sum_vy += y;
         held_count++;
      end
      if (!v.last)
         return 1'b0;
      fold_edge(prev_vx, prev_vy, first_vx, first_vy);
      mag = shoelace_acc < 0 ? -shoelace_acc : shoelace_acc;
      cx  = 16'(sum_vx / held_count);
      cy  = 16'(sum_vy / held_count);
      if (cross_acc == 0)
         res = mk_rsp(40'(mag >> 1), cx, cy, 64'd0, 1'b1, ring_dropped);
      else
         res = mk_rsp(40'(mag >> 1), cx, cy, moment_of_inertia(v.body_mass), 1'b0,
                      ring_dropped);
      clear_polygon();
      return 1'b1;
   endfunction

   // Transfer monitor and result checker
   always @(posedge clock) begin
      pmp_pkg::rsp_type res;
      if (!reset && start && !busy) begin
         if (take_vertex(req_data, res))
            mass_props_q.push_back(pin_flag ? pin_exp : res);
      end
      if (!reset && rsp_valid) begin
         results_seen++;
         if (mass_props_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: area=%0h inertia=%0h", rsp_data.area,
                        rsp_data.inertia);
         end else begin
            res = mass_props_q.pop_front();
            if (rsp_data !== res) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch %0d: area exp %0h got %0h, cx exp %0d got %0d,",
                           mismatches, res.area, rsp_data.area, res.centroid_x,
                           rsp_data.centroid_x);
                  $display("   cy exp %0d got %0d, inertia exp %0h got %0h,",
                           res.centroid_y, rsp_data.centroid_y, res.inertia,
                           rsp_data.inertia);
                  $display("   degen exp %0b got %0b, ovf exp %0b got %0b",
                           res.degenerate, rsp_data.degenerate, res.overflowed,
                           rsp_data.overflowed);
               end
            end
         end
      end
   end

   // Present one vertex and hold it until the transfer, then maybe idle
   task automatic send_vertex(pmp_pkg::req_type v, bit pin, pmp_pkg::rsp_type e,
                              int idle_pct);
      req_data <= v;
      pin_flag <= pin;
      pin_exp  <= e;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      if (v.last)
         polygons_sent++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic pmp_pkg::req_type mk_vertex(logic [15:0] x, logic [15:0] y,
                                                  logic [31:0] mass, logic last);
      pmp_pkg::req_type v;
      v.vertex_x  = x;
      v.vertex_y  = y;
      v.body_mass = mass;
      v.last      = last;
      return v;
   endfunction

   function automatic logic [15:0] rand_coord(int mode);
      if (mode == 1)
         return 16'($urandom_range(2047)) - 16'd1024;
      return 16'($urandom);
   endfunction

   // One random polygon: mostly small rings, a few past capacity, some crossed
   task automatic send_random_polygon(int idle_pct);
      int               n, mode, k, pick;
      logic [31:0]      mass;
      logic [15:0]      ax, ay, bx, by;
      pmp_pkg::rsp_type none;
      none = '0;
      pick = $urandom_range(99);
      n    = pick < 3 ? $urandom_range(60, 70) : $urandom_range(1, 8);
      mode = $urandom_range(3);
      case ($urandom_range(3))
         0: mass = 32'd0;
         1: mass = 32'hFFFF_FFFF;
         default: mass = $urandom;
      endcase
      if (mode == 3) begin
         // crossed quadrilateral, nearly cancelling cross sum
         ax = 16'($urandom); ay = 16'($urandom);
         bx = 16'($urandom); by = 16'($urandom);
         send_vertex(mk_vertex(ax, ay, mass, 1'b0), 1'b0, none, idle_pct);
         send_vertex(mk_vertex(bx, by, mass, 1'b0), 1'b0, none, idle_pct);
         send_vertex(mk_vertex(bx, ay, mass, 1'b0), 1'b0, none, idle_pct);
         send_vertex(mk_vertex(ax, by + 16'($urandom_range(2)), mass, 1'b1), 1'b0, none,
                     idle_pct);
      end else begin
         if (n > POLY_CAPACITY)
            overflow_polys++;
         for (k = 0; k < n; k++)
            send_vertex(mk_vertex(rand_coord(mode), rand_coord(mode), $urandom, k == n - 1),
                        1'b0, none, idle_pct);
      end
   endtask

   pmp_pkg::req_type dir_vtx[$];
   bit               dir_pin[$];
   pmp_pkg::rsp_type dir_exp[$];

   task automatic add_row(pmp_pkg::req_type v, bit pin, pmp_pkg::rsp_type e);
      dir_vtx.push_back(v);
      dir_pin.push_back(pin);
      dir_exp.push_back(e);
   endtask

   initial begin
      int               phase, i, idle_pct, drain;
      pmp_pkg::rsp_type none;
      none = '0;
      clear_polygon();
      mismatches = 0; results_seen = 0; polygons_sent = 0; items_sent = 0;
      overflow_polys = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      pin_flag = 1'b0;
      pin_exp  = '0;

      // Single vertices: the ring closes on itself, degenerate
      add_row(mk_vertex(16'd0, 16'd0, 32'd0, 1'b1), 1'b1,
              mk_rsp(40'd0, 16'd0, 16'd0, 64'd0, 1'b1, 1'b0));
      add_row(mk_vertex(16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 1'b1), 1'b1,
              mk_rsp(40'd0, 16'h8000, 16'h7FFF, 64'd0, 1'b1, 1'b0));
      add_row(mk_vertex(16'hFFFF, 16'h0001, 32'h0001_0000, 1'b1), 1'b1,
              mk_rsp(40'd0, 16'hFFFF, 16'h0001, 64'd0, 1'b1, 1'b0));
      // Unit triangle
      add_row(mk_vertex(16'd0, 16'd0, 32'd0, 1'b0), 1'b0, none);
      add_row(mk_vertex(16'd256, 16'd0, 32'd0, 1'b0), 1'b0, none);
      add_row(mk_vertex(16'd0, 16'd256, 32'h0001_0000, 1'b1), 1'b0, none);
      // Full-range square
      add_row(mk_vertex(16'h8000, 16'h8000, 32'd0, 1'b0), 1'b0, none);
      add_row(mk_vertex(16'h7FFF, 16'h8000, 32'd0, 1'b0), 1'b0, none);
      add_row(mk_vertex(16'h7FFF, 16'h7FFF, 32'd0, 1'b0), 1'b0, none);
      add_row(mk_vertex(16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 1'b1), 1'b0, none);
      // Symmetric bow-tie: cross sum cancels exactly
      add_row(mk_vertex(16'h8000, 16'h8000, 32'd0, 1'b0), 1'b0, none);
      add_row(mk_vertex(16'h7FFF, 16'h7FFF, 32'd0, 1'b0), 1'b0, none);
      add_row(mk_vertex(16'h7FFF, 16'h8000, 32'd0, 1'b0), 1'b0, none);
      add_row(mk_vertex(16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 1'b1), 1'b0, none);
      // Bow-tie off by one step: tiny cross sum drives inertia into saturation
      add_row(mk_vertex(16'h8000, 16'h8000, 32'd0, 1'b0), 1'b0, none);
      add_row(mk_vertex(16'h7FFF, 16'h7FFF, 32'd0, 1'b0), 1'b0, none);
      add_row(mk_vertex(16'h7FFF, 16'h8000, 32'd0, 1'b0), 1'b0, none);
      add_row(mk_vertex(16'h8000, 16'h7FFE, 32'hFFFF_FFFF, 1'b1), 1'b0, none);
      // Clockwise triangle, negative orientation
      add_row(mk_vertex(16'd0, 16'd0, 32'd0, 1'b0), 1'b0, none);
      add_row(mk_vertex(16'd0, 16'hFF00, 32'd0, 1'b0), 1'b0, none);
      add_row(mk_vertex(16'hFF00, 16'd0, 32'h0003_8000, 1'b1), 1'b0, none);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_vtx[i])
         send_vertex(dir_vtx[i], dir_pin[i], dir_exp[i], 0);

      // Past capacity, last vertex dropped too
      overflow_polys++;
      for (i = 0; i < POLY_CAPACITY + 3; i++)
         send_vertex(mk_vertex(rand_coord(0), rand_coord(0), 32'h0002_0000,
                               i == POLY_CAPACITY + 2), 1'b0, none, 0);

      // Random polygons, three idling phases
      for (phase = 0; phase < 3; phase++) begin
         idle_pct = phase == 0 ? 12 : (phase == 1 ? 57 : 0);
         while (items_sent < 1400 * (phase + 1) / 3)
            send_random_polygon(idle_pct);
      end
      start <= 1'b0;

      drain = 0;
      while (mass_props_q.size() != 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (300) @(posedge clock);

      $display("covered %0d vertices in %0d polygons, %0d past capacity,",
               items_sent, polygons_sent, overflow_polys);
      $display("%0d results checked", results_seen);
      if (mismatches == 0 && mass_props_q.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d mismatches, %0d results still owed", mismatches,
                  mass_props_q.size());
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #8_000_000;
      $display("timed out with %0d results owed", mass_props_q.size());
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pmp_pkg.sv
rtl/core/polygon_mass_properties.sv
bench/tb_top.sv
